// ===== design/kbl_pkg.sv =====
// ----------------------------------------------------------------------------
// kbl_pkg
// Shared types, codes and command constants of the keyboard backlight block.
// ----------------------------------------------------------------------------
package kbl_pkg;

    typedef enum logic [3:0] {
        OP_COLOR_NEXT = 4'd0,
        OP_LEVEL_DOWN = 4'd1,
        OP_LEVEL_UP   = 4'd2,
        OP_TOGGLE     = 4'd3,
        OP_WAKE       = 4'd4,
        OP_AIRPLANE   = 4'd5,
        OP_KEY        = 4'd6,
        OP_TICK       = 4'd7,
        OP_RESTORE    = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        KIND_LED      = 2'd0,
        KIND_REPORT   = 2'd1,
        KIND_AIRPLANE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_LEVEL0      = 3'd0,
        REG_LEVEL1      = 3'd1,
        REG_LEVEL2      = 3'd2,
        REG_LEVEL3      = 3'd3,
        REG_DIM_BRIGHT  = 3'd4,
        REG_AUTO_DIM    = 3'd5,
        REG_DIM_KEEPS   = 3'd6,
        REG_DIM_TIMEOUT = 3'd7
    } reg_idx_t;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CFG_WIDTH   = 21;

    localparam logic [31:0] LED_ON      = 32'hE007F001;
    localparam logic [31:0] LED_OFF     = 32'hE0003001;
    localparam logic [31:0] LEVEL_CMD   = 32'hF4000000;
    localparam logic [31:0] COLOR_CMD0  = 32'hF0000000;
    localparam logic [31:0] COLOR_CMD1  = 32'hF1000000;
    localparam logic [31:0] COLOR_CMD2  = 32'hF2000000;
    localparam logic [31:0] RGB_CMD0    = 32'hF000FF00;
    localparam logic [31:0] RGB_CMD1    = 32'hF10000FF;
    localparam logic [31:0] RGB_CMD2    = 32'hF2FF0000;
    localparam logic [31:0] WHITE_CMD   = 32'h70000000;

    localparam logic [11:0] WORD_RESET  = 12'h012;
    localparam logic [11:0] OFF_MASK    = 12'hF0F;
    localparam logic [11:0] ON_BIT      = 12'h010;
    localparam logic [3:0]  COLOR_RGB   = 4'd7;
    localparam logic [3:0]  COLOR_WHITE = 4'd8;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] command_word;
        logic [2:0]  report_level;
        logic [11:0] backlight_word;
    } result_t;

    // 24-bit color value of the plain colors 0-6
    function automatic logic [31:0] color_value(input logic [2:0] c);
        logic [31:0] v;
        unique case (c)
            3'd0:    v = 32'h00FF0000;
            3'd1:    v = 32'h0000FF00;
            3'd2:    v = 32'h00FFFFFF;
            3'd3:    v = 32'h00FFFF00;
            3'd4:    v = 32'h00FF00FF;
            3'd5:    v = 32'h000000FF;
            3'd6:    v = 32'h0000FFFF;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // number of color commands sent for a color code
    function automatic logic [1:0] color_count(input logic [3:0] c);
        logic [1:0] n;
        if (c < COLOR_RGB)
            n = 2'd3;
        else if (c == COLOR_RGB)
            n = 2'd3;
        else if (c == COLOR_WHITE)
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

    // k-th color command of a color code
    function automatic logic [31:0] color_cmd(input logic [3:0] c, input logic [1:0] k);
        logic [31:0] w;
        if (c < COLOR_RGB) begin
            unique case (k)
                2'd0:    w = COLOR_CMD0 | color_value(c[2:0]);
                2'd1:    w = COLOR_CMD1 | color_value(c[2:0]);
                default: w = COLOR_CMD2 | color_value(c[2:0]);
            endcase
        end
        else if (c == COLOR_RGB) begin
            unique case (k)
                2'd0:    w = RGB_CMD0;
                2'd1:    w = RGB_CMD1;
                default: w = RGB_CMD2;
            endcase
        end
        else begin
            w = WHITE_CMD;
        end
        return w;
    endfunction

endpackage

// ===== design/kbl_in_if.sv =====
// ----------------------------------------------------------------------------
// kbl_in_if
// Event channel: valid/ready handshake with op code and saved word.
// ----------------------------------------------------------------------------
interface kbl_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [11:0] saved_word;

    modport source (output valid, output op, output saved_word, input ready);
    modport sink   (input valid, input op, input saved_word, output ready);
endinterface

// ===== design/kbl_out_if.sv =====
// ----------------------------------------------------------------------------
// kbl_out_if
// Result channel: valid/ready handshake with one LED command or report.
// ----------------------------------------------------------------------------
interface kbl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] command_word;
    logic [2:0]  report_level;
    logic [11:0] backlight_word;
    logic        last;

    modport source (output valid, output kind, output command_word, output report_level,
                    output backlight_word, output last, input ready);
    modport sink   (input valid, input kind, input command_word, input report_level,
                    input backlight_word, input last, output ready);
endinterface

// ===== design/keyboard_backlight_controller.sv =====
// ----------------------------------------------------------------------------
// keyboard_backlight_controller
// Backlight state, auto-dim countdown and LED command generation.
// ----------------------------------------------------------------------------
// Each accepted event is decoded in the cycle it is taken: the backlight word,
// flags and dim countdown update at once and the up to six results it causes
// are loaded into a six-entry result queue that drains one result per cycle
// while the result side is ready. An event therefore holds the output until
// all of its results are delivered (none to six; a toggle has the most), and
// a new event is taken in the same cycle the final result of the previous
// one is delivered, or at once when the queue is empty. Each result carries
// the backlight word as it stands when that result is made; a level command
// clears bits 3:2 of the word, so earlier results of a setup may still show
// them.
module keyboard_backlight_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [kbl_pkg::CFG_WIDTH-1:0] cfg_data,
    kbl_in_if.sink                        events,
    kbl_out_if.source                     results
);

    // configuration registers
    logic [7:0]  level_word_reg [4];
    logic [3:0]  dim_brightness_reg;
    logic        auto_dim_enable_reg;
    logic        dim_keeps_light_reg;
    logic [20:0] dim_timeout_reg;

    // backlight state
    logic [11:0] light_word_reg, light_word_next;
    logic        switched_off_reg, switched_off_next;
    logic        is_dimmed_reg, is_dimmed_next;
    logic        dim_armed_reg, dim_armed_next;
    logic [20:0] dim_remaining_reg, dim_remaining_next;

    // result queue
    kbl_pkg::result_t queue_reg [kbl_pkg::MAX_RESULTS];
    kbl_pkg::result_t list_next [kbl_pkg::MAX_RESULTS];
    logic [2:0]       count_reg;
    logic [2:0]       list_count;

    logic accept;
    logic take;

    assign take   = results.valid && results.ready;
    assign events.ready = (count_reg == 3'd0) || (count_reg == 3'd1 && results.ready);
    assign accept = events.valid && events.ready;

    assign results.valid          = (count_reg != 3'd0);
    assign results.kind           = queue_reg[0].kind;
    assign results.command_word   = queue_reg[0].command_word;
    assign results.report_level   = queue_reg[0].report_level;
    assign results.backlight_word = queue_reg[0].backlight_word;
    assign results.last           = (count_reg == 3'd1);

    // event decode: next state and result list
    always_comb
    begin
        logic [11:0] w;
        logic [1:0]  lv;
        logic [2:0]  n;
        logic        setup;
        logic [3:0]  c;
        logic [1:0]  cc;

        w      = light_word_reg;
        lv     = light_word_reg[1:0];
        n      = 3'd0;
        setup  = 1'b0;
        c      = 4'd0;
        cc     = 2'd0;

        switched_off_next  = switched_off_reg;
        is_dimmed_next     = is_dimmed_reg;
        dim_armed_next     = dim_armed_reg;
        dim_remaining_next = dim_remaining_reg;

        for (int i = 0; i < kbl_pkg::MAX_RESULTS; i++)
        begin
            list_next[i] = '{kind: kbl_pkg::KIND_LED, command_word: 32'd0,
                             report_level: 3'd0, backlight_word: 12'd0};
        end

        unique case (events.op)
            kbl_pkg::OP_COLOR_NEXT:
            begin
                if (!switched_off_reg)
                begin
                    c = w[11:8];
                    w[11:8] = (c < kbl_pkg::COLOR_WHITE) ? c + 4'd1 : 4'd0;
                    cc = kbl_pkg::color_count(w[11:8]);
                    for (int k = 0; k < 3; k++)
                    begin
                        if (2'(k) < cc)
                        begin
                            list_next[n].command_word = kbl_pkg::color_cmd(w[11:8], 2'(k));
                            list_next[n].backlight_word = w;
                            n = n + 3'd1;
                        end
                    end
                end
            end
            kbl_pkg::OP_LEVEL_DOWN, kbl_pkg::OP_LEVEL_UP:
            begin
                if (!switched_off_reg)
                begin
                    if (events.op == kbl_pkg::OP_LEVEL_DOWN ? lv != 2'd0 : lv != 2'd3)
                    begin
                        lv = (events.op == kbl_pkg::OP_LEVEL_DOWN) ? lv - 2'd1 : lv + 2'd1;
                        // a level command clears bits 3:2 of the word
                        w = {w[11:4], 2'b00, lv};
                        list_next[n].command_word = kbl_pkg::LEVEL_CMD
                                                    | {24'd0, level_word_reg[lv]};
                        list_next[n].backlight_word = w;
                        n = n + 3'd1;
                    end
                    list_next[n].kind = kbl_pkg::KIND_REPORT;
                    list_next[n].report_level = {1'b0, lv} + 3'd1;
                    list_next[n].backlight_word = w;
                    n = n + 3'd1;
                end
            end
            kbl_pkg::OP_TOGGLE:
            begin
                if (!switched_off_reg)
                begin
                    w = w & kbl_pkg::OFF_MASK;
                    switched_off_next = 1'b1;
                end
                else
                begin
                    w = w | kbl_pkg::ON_BIT;
                    switched_off_next = 1'b0;
                end
                list_next[n].kind = kbl_pkg::KIND_REPORT;
                list_next[n].report_level = switched_off_next ? 3'd0 : {1'b0, lv} + 3'd1;
                list_next[n].backlight_word = w;
                n = n + 3'd1;
                setup = 1'b1;
            end
            kbl_pkg::OP_WAKE:
            begin
                setup = 1'b1;
            end
            kbl_pkg::OP_AIRPLANE:
            begin
                list_next[n].kind = kbl_pkg::KIND_AIRPLANE;
                list_next[n].backlight_word = w;
                n = n + 3'd1;
            end
            kbl_pkg::OP_KEY:
            begin
                if (auto_dim_enable_reg && !switched_off_reg)
                begin
                    dim_armed_next     = 1'b1;
                    dim_remaining_next = dim_timeout_reg;
                    if (is_dimmed_reg && w[4])
                    begin
                        setup          = 1'b1;
                        is_dimmed_next = 1'b0;
                    end
                end
            end
            kbl_pkg::OP_TICK:
            begin
                if (dim_armed_reg)
                begin
                    if (dim_remaining_reg <= 21'd1)
                    begin
                        dim_remaining_next = 21'd0;
                        dim_armed_next     = 1'b0;
                        is_dimmed_next     = 1'b1;
                        list_next[n].command_word = kbl_pkg::LEVEL_CMD
                            | {28'd0, dim_keeps_light_reg ? dim_brightness_reg : 4'd0};
                        list_next[n].backlight_word = w;
                        n = n + 3'd1;
                    end
                    else
                    begin
                        dim_remaining_next = dim_remaining_reg - 21'd1;
                    end
                end
            end
            kbl_pkg::OP_RESTORE:
            begin
                w = events.saved_word;
                setup = 1'b1;
            end
            default:
            begin
            end
        endcase

        // full setup: colors, level and on command, or the off command
        if (setup)
        begin
            if (w[4])
            begin
                cc = kbl_pkg::color_count(w[11:8]);
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) < cc)
                    begin
                        list_next[n].command_word = kbl_pkg::color_cmd(w[11:8], 2'(k));
                        list_next[n].backlight_word = w;
                        n = n + 3'd1;
                    end
                end
                w = {w[11:4], 2'b00, w[1:0]};
                list_next[n].command_word = kbl_pkg::LEVEL_CMD
                                            | {24'd0, level_word_reg[w[1:0]]};
                list_next[n].backlight_word = w;
                n = n + 3'd1;
                list_next[n].command_word = kbl_pkg::LED_ON;
                list_next[n].backlight_word = w;
                n = n + 3'd1;
                dim_armed_next     = 1'b1;
                dim_remaining_next = dim_timeout_reg;
            end
            else
            begin
                list_next[n].command_word = kbl_pkg::LED_OFF;
                list_next[n].backlight_word = w;
                n = n + 3'd1;
                dim_armed_next     = 1'b0;
                dim_remaining_next = 21'd0;
            end
        end

        light_word_next = w;
        list_count      = n;
    end

    // configuration and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_word_reg[0]   <= 8'd0;
            level_word_reg[1]   <= 8'd64;
            level_word_reg[2]   <= 8'd128;
            level_word_reg[3]   <= 8'd255;
            dim_brightness_reg  <= 4'd1;
            auto_dim_enable_reg <= 1'b1;
            dim_keeps_light_reg <= 1'b1;
            dim_timeout_reg     <= 21'd60000;
            light_word_reg      <= kbl_pkg::WORD_RESET;
            switched_off_reg    <= 1'b0;
            is_dimmed_reg       <= 1'b1;
            dim_armed_reg       <= 1'b0;
            dim_remaining_reg   <= 21'd0;
            count_reg           <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (kbl_pkg::reg_idx_t'(cfg_index))
                    kbl_pkg::REG_LEVEL0:      level_word_reg[0]   <= cfg_data[7:0];
                    kbl_pkg::REG_LEVEL1:      level_word_reg[1]   <= cfg_data[7:0];
                    kbl_pkg::REG_LEVEL2:      level_word_reg[2]   <= cfg_data[7:0];
                    kbl_pkg::REG_LEVEL3:      level_word_reg[3]   <= cfg_data[7:0];
                    kbl_pkg::REG_DIM_BRIGHT:  dim_brightness_reg  <= cfg_data[3:0];
                    kbl_pkg::REG_AUTO_DIM:    auto_dim_enable_reg <= cfg_data[0];
                    kbl_pkg::REG_DIM_KEEPS:   dim_keeps_light_reg <= cfg_data[0];
                    kbl_pkg::REG_DIM_TIMEOUT: dim_timeout_reg     <= cfg_data[20:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                light_word_reg    <= light_word_next;
                switched_off_reg  <= switched_off_next;
                is_dimmed_reg     <= is_dimmed_next;
                dim_armed_reg     <= dim_armed_next;
                dim_remaining_reg <= dim_remaining_next;
                count_reg         <= list_count;
            end
            else if (take)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

    // result queue payload, head at entry zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < kbl_pkg::MAX_RESULTS; i++)
            begin
                queue_reg[i] <= list_next[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < kbl_pkg::MAX_RESULTS - 1; i++)
            begin
                queue_reg[i] <= queue_reg[i + 1];
            end
        end
    end

endmodule

// ===== tb/keyboard_backlight_checker.sv =====
// ----------------------------------------------------------------------------
// keyboard_backlight_checker
// Watches the config port and both channels, keeps its own copy of the
// backlight state and dim countdown, predicts the results of every accepted
// event and compares them in order against the delivered results.
// ----------------------------------------------------------------------------
module keyboard_backlight_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [kbl_pkg::CFG_WIDTH-1:0] cfg_data,
    kbl_in_if                             events,
    kbl_out_if                            results,
    output int                            failures,
    output int                            outstanding
);

    typedef struct packed {
        kbl_pkg::kind_t kind;
        logic [31:0]    command_word;
        logic [2:0]     report_level;
        logic [11:0]    backlight_word;
        logic           last;
    } light_result_t;

    // register copies
    logic [7:0]  level_byte [4];
    logic [3:0]  dim_byte;
    logic        auto_dim;
    logic        keeps_light;
    logic [20:0] timeout;

    // backlight state copies
    logic [11:0] word;
    logic        off_flag;
    logic        dimmed;
    logic        armed;
    logic [20:0] remaining;

    light_result_t expected_results [$];
    light_result_t burst [kbl_pkg::MAX_RESULTS];
    int            burst_len;

    function automatic logic [31:0] plain_color(input logic [2:0] c);
        logic [31:0] rgb;
        case (c)
            3'd0:    rgb = 32'h00FF0000;
            3'd1:    rgb = 32'h0000FF00;
            3'd2:    rgb = 32'h00FFFFFF;
            3'd3:    rgb = 32'h00FFFF00;
            3'd4:    rgb = 32'h00FF00FF;
            3'd5:    rgb = 32'h000000FF;
            default: rgb = 32'h0000FFFF;
        endcase
        return rgb;
    endfunction

    // every result carries the word as it stands when the result is made
    task automatic add_result(input kbl_pkg::kind_t k, input logic [31:0] cmd,
                              input logic [2:0] lvl);
        if (burst_len < kbl_pkg::MAX_RESULTS)
        begin
            burst[burst_len].kind           = k;
            burst[burst_len].command_word   = cmd;
            burst[burst_len].report_level   = lvl;
            burst[burst_len].backlight_word = word;
            burst[burst_len].last           = 1'b0;
            burst_len++;
        end
    endtask

    task automatic emit_colors();
        logic [3:0] c;
        c = word[11:8];
        if (c < kbl_pkg::COLOR_RGB)
        begin
            add_result(kbl_pkg::KIND_LED, kbl_pkg::COLOR_CMD0 | plain_color(c[2:0]), 3'd0);
            add_result(kbl_pkg::KIND_LED, kbl_pkg::COLOR_CMD1 | plain_color(c[2:0]), 3'd0);
            add_result(kbl_pkg::KIND_LED, kbl_pkg::COLOR_CMD2 | plain_color(c[2:0]), 3'd0);
        end
        else if (c == kbl_pkg::COLOR_RGB)
        begin
            add_result(kbl_pkg::KIND_LED, kbl_pkg::RGB_CMD0, 3'd0);
            add_result(kbl_pkg::KIND_LED, kbl_pkg::RGB_CMD1, 3'd0);
            add_result(kbl_pkg::KIND_LED, kbl_pkg::RGB_CMD2, 3'd0);
        end
        else if (c == kbl_pkg::COLOR_WHITE)
        begin
            add_result(kbl_pkg::KIND_LED, kbl_pkg::WHITE_CMD, 3'd0);
        end
    endtask

    // clears bits 3:2 of the word as a side effect
    task automatic apply_level(input logic [1:0] lv);
        word = {word[11:4], 2'b00, lv};
        add_result(kbl_pkg::KIND_LED, kbl_pkg::LEVEL_CMD | {24'd0, level_byte[lv]}, 3'd0);
    endtask

    task automatic run_setup();
        if ((word & kbl_pkg::ON_BIT) != 12'd0)
        begin
            emit_colors();
            apply_level(word[1:0]);
            armed     = 1'b1;
            remaining = timeout;
            add_result(kbl_pkg::KIND_LED, kbl_pkg::LED_ON, 3'd0);
        end
        else
        begin
            armed     = 1'b0;
            remaining = '0;
            add_result(kbl_pkg::KIND_LED, kbl_pkg::LED_OFF, 3'd0);
        end
    endtask

    task automatic predict_event(input logic [3:0] op, input logic [11:0] saved);
        logic [1:0] lv;
        logic [3:0] c;
        lv        = word[1:0];
        burst_len = 0;
        case (op)
            kbl_pkg::OP_COLOR_NEXT:
                if (!off_flag)
                begin
                    c    = word[11:8];
                    word = {(c < kbl_pkg::COLOR_WHITE) ? c + 4'd1 : 4'd0, word[7:0]};
                    emit_colors();
                end
            kbl_pkg::OP_LEVEL_DOWN:
                if (!off_flag)
                begin
                    if (lv > 2'd0)
                    begin
                        lv = lv - 2'd1;
                        apply_level(lv);
                    end
                    add_result(kbl_pkg::KIND_REPORT, 32'd0, {1'b0, lv} + 3'd1);
                end
            kbl_pkg::OP_LEVEL_UP:
                if (!off_flag)
                begin
                    if (lv < 2'd3)
                    begin
                        lv = lv + 2'd1;
                        apply_level(lv);
                    end
                    add_result(kbl_pkg::KIND_REPORT, 32'd0, {1'b0, lv} + 3'd1);
                end
            kbl_pkg::OP_TOGGLE:
            begin
                if (!off_flag)
                begin
                    word     = word & kbl_pkg::OFF_MASK;
                    off_flag = 1'b1;
                end
                else
                begin
                    word     = word | kbl_pkg::ON_BIT;
                    off_flag = 1'b0;
                end
                add_result(kbl_pkg::KIND_REPORT, 32'd0,
                           off_flag ? 3'd0 : {1'b0, lv} + 3'd1);
                run_setup();
            end
            kbl_pkg::OP_WAKE:
                run_setup();
            kbl_pkg::OP_AIRPLANE:
                add_result(kbl_pkg::KIND_AIRPLANE, 32'd0, 3'd0);
            kbl_pkg::OP_KEY:
                if (auto_dim && !off_flag)
                begin
                    armed     = 1'b1;
                    remaining = timeout;
                    if (dimmed && (word & kbl_pkg::ON_BIT) != 12'd0)
                    begin
                        run_setup();
                        dimmed = 1'b0;
                    end
                end
            kbl_pkg::OP_TICK:
                if (armed)
                begin
                    if (remaining <= 21'd1)
                    begin
                        remaining = '0;
                        armed     = 1'b0;
                        dimmed    = 1'b1;
                        add_result(kbl_pkg::KIND_LED, kbl_pkg::LEVEL_CMD
                                   | {28'd0, keeps_light ? dim_byte : 4'd0}, 3'd0);
                    end
                    else
                    begin
                        remaining = remaining - 21'd1;
                    end
                end
            kbl_pkg::OP_RESTORE:
            begin
                word = saved;
                run_setup();
            end
            default: ;
        endcase
        for (int i = 0; i < burst_len; i++)
        begin
            if (i == burst_len - 1)
                burst[i].last = 1'b1;
            expected_results.push_back(burst[i]);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [kbl_pkg::CFG_WIDTH-1:0] data);
        case (kbl_pkg::reg_idx_t'(idx))
            kbl_pkg::REG_LEVEL0:      level_byte[0] = data[7:0];
            kbl_pkg::REG_LEVEL1:      level_byte[1] = data[7:0];
            kbl_pkg::REG_LEVEL2:      level_byte[2] = data[7:0];
            kbl_pkg::REG_LEVEL3:      level_byte[3] = data[7:0];
            kbl_pkg::REG_DIM_BRIGHT:  dim_byte      = data[3:0];
            kbl_pkg::REG_AUTO_DIM:    auto_dim      = data[0];
            kbl_pkg::REG_DIM_KEEPS:   keeps_light   = data[0];
            kbl_pkg::REG_DIM_TIMEOUT: timeout       = data[20:0];
            default: ;
        endcase
    endtask

    task automatic check_result();
        light_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transaction: kind %0d command_word %h",
                   results.kind, results.command_word);
            failures++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (results.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, results.kind);
                failures++;
            end
            if (results.command_word !== want.command_word)
            begin
                $error("command_word: expected %h, got %h",
                       want.command_word, results.command_word);
                failures++;
            end
            if (results.report_level !== want.report_level)
            begin
                $error("report_level: expected %0d, got %0d",
                       want.report_level, results.report_level);
                failures++;
            end
            if (results.backlight_word !== want.backlight_word)
            begin
                $error("backlight_word: expected %h, got %h",
                       want.backlight_word, results.backlight_word);
                failures++;
            end
            if (results.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, results.last);
                failures++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_byte[0] = 8'd0;
            level_byte[1] = 8'd64;
            level_byte[2] = 8'd128;
            level_byte[3] = 8'd255;
            dim_byte      = 4'd1;
            auto_dim      = 1'b1;
            keeps_light   = 1'b1;
            timeout       = 21'd60000;
            word          = kbl_pkg::WORD_RESET;
            off_flag      = 1'b0;
            dimmed        = 1'b1;
            armed         = 1'b0;
            remaining     = '0;
            failures      = 0;
            expected_results.delete();
        end
        else
        begin
            // an event decodes with the registers as they stood before this edge
            if (events.valid && events.ready)
                predict_event(events.op, events.saved_word);
            if (cfg_we)
                write_reg(cfg_index, cfg_data);
            if (results.valid && results.ready)
                check_result();
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/keyboard_backlight_controller_tb.sv =====
// ----------------------------------------------------------------------------
// keyboard_backlight_controller_tb
// Drives directed and random backlight events through several register
// settings, with random idle and stall cycles on both channels, and reports
// the verdict from the failure and outstanding counts of the checker.
// ----------------------------------------------------------------------------
module keyboard_backlight_controller_tb;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [2:0]                    cfg_index;
    logic [kbl_pkg::CFG_WIDTH-1:0] cfg_data;
    int                            failures;
    int                            outstanding;
    bit                            idle_on;

    kbl_in_if  event_ch ();
    kbl_out_if result_ch ();

    keyboard_backlight_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (event_ch),
        .results   (result_ch)
    );

    keyboard_backlight_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .events      (event_ch),
        .results     (result_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(8 * 1500000);
        $display("TEST FAILED");
        $finish;
    end

    // every task below starts and ends at a falling edge
    task automatic send_event(input logic [3:0] op, input logic [11:0] saved);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            event_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        event_ch.valid      = 1'b1;
        event_ch.op         = op;
        event_ch.saved_word = saved;
        do
            @(posedge clk);
        while (!event_ch.ready);
        @(negedge clk);
    endtask

    task automatic settle();
        event_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_reg(input kbl_pkg::reg_idx_t idx,
                               input logic [kbl_pkg::CFG_WIDTH-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic configure(input logic [7:0] l0, input logic [7:0] l1,
                             input logic [7:0] l2, input logic [7:0] l3,
                             input logic [3:0] dim_level, input logic auto_en,
                             input logic keeps, input logic [20:0] ticks);
        settle();
        program_reg(kbl_pkg::REG_LEVEL0, {13'd0, l0});
        program_reg(kbl_pkg::REG_LEVEL1, {13'd0, l1});
        program_reg(kbl_pkg::REG_LEVEL2, {13'd0, l2});
        program_reg(kbl_pkg::REG_LEVEL3, {13'd0, l3});
        program_reg(kbl_pkg::REG_DIM_BRIGHT, {17'd0, dim_level});
        program_reg(kbl_pkg::REG_AUTO_DIM, {20'd0, auto_en});
        program_reg(kbl_pkg::REG_DIM_KEEPS, {20'd0, keeps});
        program_reg(kbl_pkg::REG_DIM_TIMEOUT, ticks);
    endtask

    task automatic random_burst(input int count);
        int          pick;
        logic [3:0]  op;
        logic [11:0] saved;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)       op = kbl_pkg::OP_COLOR_NEXT;
            else if (pick < 16) op = kbl_pkg::OP_LEVEL_DOWN;
            else if (pick < 24) op = kbl_pkg::OP_LEVEL_UP;
            else if (pick < 32) op = kbl_pkg::OP_TOGGLE;
            else if (pick < 38) op = kbl_pkg::OP_WAKE;
            else if (pick < 43) op = kbl_pkg::OP_AIRPLANE;
            else if (pick < 58) op = kbl_pkg::OP_KEY;
            else if (pick < 85) op = kbl_pkg::OP_TICK;
            else if (pick < 95) op = kbl_pkg::OP_RESTORE;
            else                op = 4'($urandom_range(9, 15));
            // half the saved words are plausible lit settings
            if ($urandom_range(0, 1))
                saved = 12'($urandom);
            else
                saved = {4'($urandom_range(0, 8)), 3'($urandom_range(0, 7)), 1'b1,
                         4'($urandom_range(0, 15))};
            send_event(op, saved);
            if ($urandom_range(0, 29) == 0)
                settle();
        end
    endtask

    // result side: random stall before each transaction while idle_on is set
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        forever
        begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        event_ch.valid      = 1'b0;
        event_ch.op         = '0;
        event_ch.saved_word = '0;
        idle_on             = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed pass on reset settings
        send_event(kbl_pkg::OP_TICK, 12'h000);
        send_event(kbl_pkg::OP_KEY, 12'h000);
        send_event(kbl_pkg::OP_LEVEL_UP, 12'h000);
        send_event(kbl_pkg::OP_LEVEL_UP, 12'h000);
        repeat (3) send_event(kbl_pkg::OP_LEVEL_DOWN, 12'h000);
        send_event(kbl_pkg::OP_LEVEL_DOWN, 12'h000);
        send_event(kbl_pkg::OP_COLOR_NEXT, 12'h000);
        send_event(kbl_pkg::OP_RESTORE, 12'h712);
        send_event(kbl_pkg::OP_COLOR_NEXT, 12'h000);
        send_event(kbl_pkg::OP_COLOR_NEXT, 12'h000);
        send_event(kbl_pkg::OP_RESTORE, 12'hF1F);
        send_event(kbl_pkg::OP_COLOR_NEXT, 12'hFFF);
        send_event(kbl_pkg::OP_TOGGLE, 12'h000);
        send_event(kbl_pkg::OP_COLOR_NEXT, 12'h000);
        send_event(kbl_pkg::OP_LEVEL_UP, 12'h000);
        send_event(kbl_pkg::OP_KEY, 12'h000);
        send_event(kbl_pkg::OP_TOGGLE, 12'h000);
        send_event(kbl_pkg::OP_WAKE, 12'h000);
        send_event(kbl_pkg::OP_AIRPLANE, 12'h000);
        send_event(kbl_pkg::OP_RESTORE, 12'h000);
        send_event(4'd9, 12'hAAA);
        send_event(4'd15, 12'h555);
        send_event(kbl_pkg::OP_RESTORE, 12'h6D3);

        // zero countdown dims on the first tick
        configure(8'd255, 8'd0, 8'd255, 8'd0, 4'd15, 1'b1, 1'b1, 21'd0);
        send_event(kbl_pkg::OP_RESTORE, 12'h012);
        send_event(kbl_pkg::OP_TICK, 12'h000);
        send_event(kbl_pkg::OP_KEY, 12'h000);
        send_event(kbl_pkg::OP_TICK, 12'h000);
        random_burst(60);

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  4'd0, 1'b0, 1'b0, 21'd1);
        random_burst(60);

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  4'd7, 1'b1, 1'b0, 21'($urandom_range(2, 12)));
        random_burst(60);

        // a timeout of 5000, so eight ticks stay far from the dim
        configure(8'd1, 8'd2, 8'd254, 8'd128, 4'd3, 1'b1, 1'b1, 21'd5000);
        idle_on = 1'b0;
        send_event(kbl_pkg::OP_RESTORE, 12'h312);
        repeat (8) send_event(kbl_pkg::OP_TICK, 12'h000);
        send_event(kbl_pkg::OP_KEY, 12'h000);
        random_burst(20);

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  4'($urandom), 1'b1, 1'b1, 21'd1800000);
        random_burst(40);

        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  4'($urandom), 1'($urandom), 1'($urandom), 21'($urandom_range(1, 12)));
        random_burst(60);

        settle();
        repeat (8) @(negedge clk);
        if (failures == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kbl_pkg.sv
design/kbl_in_if.sv
design/kbl_out_if.sv
design/keyboard_backlight_controller.sv
tb/keyboard_backlight_checker.sv
tb/keyboard_backlight_controller_tb.sv
